// ===== rtl/aes128_key_expansion_core_defines.svh =====
// Assertion macros shared by the AES-128 key expansion RTL.
`ifndef AES128_KEY_EXPANSION_CORE_DEFINES_SVH
`define AES128_KEY_EXPANSION_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AESKX_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define AESKX_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/aeskx_pkg.sv =====
// Shared types, constants and table functions of the AES-128 key expansion core.
package aeskx_pkg;

  localparam int unsigned WordW   = 32;
  localparam int unsigned NumWords = 4;
  localparam int unsigned RoundW  = 4;
  localparam logic [RoundW-1:0] LastRound = 4'd10;

  // Control handed from the sequencer to every word cell.
  typedef struct packed {
    logic load;
    logic step;
  } cell_ctrl_t;

  localparam logic [7:0] SBOX [0:255] = '{
    8'h63, 8'h7c, 8'h77, 8'h7b, 8'hf2, 8'h6b, 8'h6f, 8'hc5,
    8'h30, 8'h01, 8'h67, 8'h2b, 8'hfe, 8'hd7, 8'hab, 8'h76,
    8'hca, 8'h82, 8'hc9, 8'h7d, 8'hfa, 8'h59, 8'h47, 8'hf0,
    8'had, 8'hd4, 8'ha2, 8'haf, 8'h9c, 8'ha4, 8'h72, 8'hc0,
    8'hb7, 8'hfd, 8'h93, 8'h26, 8'h36, 8'h3f, 8'hf7, 8'hcc,
    8'h34, 8'ha5, 8'he5, 8'hf1, 8'h71, 8'hd8, 8'h31, 8'h15,
    8'h04, 8'hc7, 8'h23, 8'hc3, 8'h18, 8'h96, 8'h05, 8'h9a,
    8'h07, 8'h12, 8'h80, 8'he2, 8'heb, 8'h27, 8'hb2, 8'h75,
    8'h09, 8'h83, 8'h2c, 8'h1a, 8'h1b, 8'h6e, 8'h5a, 8'ha0,
    8'h52, 8'h3b, 8'hd6, 8'hb3, 8'h29, 8'he3, 8'h2f, 8'h84,
    8'h53, 8'hd1, 8'h00, 8'hed, 8'h20, 8'hfc, 8'hb1, 8'h5b,
    8'h6a, 8'hcb, 8'hbe, 8'h39, 8'h4a, 8'h4c, 8'h58, 8'hcf,
    8'hd0, 8'hef, 8'haa, 8'hfb, 8'h43, 8'h4d, 8'h33, 8'h85,
    8'h45, 8'hf9, 8'h02, 8'h7f, 8'h50, 8'h3c, 8'h9f, 8'ha8,
    8'h51, 8'ha3, 8'h40, 8'h8f, 8'h92, 8'h9d, 8'h38, 8'hf5,
    8'hbc, 8'hb6, 8'hda, 8'h21, 8'h10, 8'hff, 8'hf3, 8'hd2,
    8'hcd, 8'h0c, 8'h13, 8'hec, 8'h5f, 8'h97, 8'h44, 8'h17,
    8'hc4, 8'ha7, 8'h7e, 8'h3d, 8'h64, 8'h5d, 8'h19, 8'h73,
    8'h60, 8'h81, 8'h4f, 8'hdc, 8'h22, 8'h2a, 8'h90, 8'h88,
    8'h46, 8'hee, 8'hb8, 8'h14, 8'hde, 8'h5e, 8'h0b, 8'hdb,
    8'he0, 8'h32, 8'h3a, 8'h0a, 8'h49, 8'h06, 8'h24, 8'h5c,
    8'hc2, 8'hd3, 8'hac, 8'h62, 8'h91, 8'h95, 8'he4, 8'h79,
    8'he7, 8'hc8, 8'h37, 8'h6d, 8'h8d, 8'hd5, 8'h4e, 8'ha9,
    8'h6c, 8'h56, 8'hf4, 8'hea, 8'h65, 8'h7a, 8'hae, 8'h08,
    8'hba, 8'h78, 8'h25, 8'h2e, 8'h1c, 8'ha6, 8'hb4, 8'hc6,
    8'he8, 8'hdd, 8'h74, 8'h1f, 8'h4b, 8'hbd, 8'h8b, 8'h8a,
    8'h70, 8'h3e, 8'hb5, 8'h66, 8'h48, 8'h03, 8'hf6, 8'h0e,
    8'h61, 8'h35, 8'h57, 8'hb9, 8'h86, 8'hc1, 8'h1d, 8'h9e,
    8'he1, 8'hf8, 8'h98, 8'h11, 8'h69, 8'hd9, 8'h8e, 8'h94,
    8'h9b, 8'h1e, 8'h87, 8'he9, 8'hce, 8'h55, 8'h28, 8'hdf,
    8'h8c, 8'ha1, 8'h89, 8'h0d, 8'hbf, 8'he6, 8'h42, 8'h68,
    8'h41, 8'h99, 8'h2d, 8'h0f, 8'hb0, 8'h54, 8'hbb, 8'h16
  };

  function automatic logic [7:0] sub_byte(input logic [7:0] b);
    return SBOX[b];
  endfunction

  // Round constant used when moving from round key r to round key r + 1.
  function automatic logic [7:0] rcon(input logic [RoundW-1:0] r);
    logic [7:0] c;
    unique case (r)
      4'd0:    c = 8'h01;
      4'd1:    c = 8'h02;
      4'd2:    c = 8'h04;
      4'd3:    c = 8'h08;
      4'd4:    c = 8'h10;
      4'd5:    c = 8'h20;
      4'd6:    c = 8'h40;
      4'd7:    c = 8'h80;
      4'd8:    c = 8'h1b;
      4'd9:    c = 8'h36;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/aes128_key_expansion_core.sv =====
// Top level of the AES-128 key expansion core.
//
//   Channel  Direction  Payload                                         Flow
//   in_      input      key_high, key_low                               in_valid / in_stall
//   out_     output     round_number, round_key_high/low, last_key      out_valid / out_stall
//
// Each key yields eleven round-key transactions, one per cycle when the output is not stalled:
// a row of four word cells advances one round per cycle through a single shared S-box step.
// A key occupies the core from its accepting cycle through its eleven round keys and any output
// stall. The next key can be accepted in the cycle after round key 10 is taken.
// in_stall is high while a run is in progress.
// Reset clears only the output valid flag and the round counter.
// While out_stall is high the current round key is held and the cells do not advance.
`include "aes128_key_expansion_core_defines.svh"

module aes128_key_expansion_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_key_high,
  input  logic [63:0] in_key_low,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_round_number,
  output logic [63:0] out_round_key_high,
  output logic [63:0] out_round_key_low,
  output logic        out_last_key
);

  localparam int unsigned NumWords = aeskx_pkg::NumWords;
  localparam int unsigned WordW    = aeskx_pkg::WordW;

  logic                               out_valid_r;
  logic                               out_valid_nxt;
  logic [aeskx_pkg::RoundW-1:0]       round_r;
  logic [aeskx_pkg::RoundW-1:0]       round_nxt;
  logic                               in_fire;
  logic                               out_fire;
  logic                               is_last;
  aeskx_pkg::cell_ctrl_t              ctrl;
  logic [WordW-1:0]                   load_words [0:NumWords-1];
  logic [WordW-1:0]                   words      [0:NumWords-1];
  logic [WordW-1:0]                   chain      [0:NumWords];
  logic [WordW-1:0]                   g_word;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid_r && !out_stall;
  assign is_last  = (round_r == aeskx_pkg::LastRound);

  assign ctrl.load = in_fire;
  assign ctrl.step = out_fire && !is_last;

  assign load_words[0] = in_key_high[63:32];
  assign load_words[1] = in_key_high[31:0];
  assign load_words[2] = in_key_low[63:32];
  assign load_words[3] = in_key_low[31:0];

  aeskx_gfunc u_gfunc (
    .word_in   (words[NumWords-1]),
    .rcon_byte (aeskx_pkg::rcon(round_r)),
    .word_out  (g_word)
  );

  assign chain[0] = g_word;

  for (genvar i = 0; i < NumWords; i++) begin : g_cell
    aeskx_word_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .load_word (load_words[i]),
      .chain_in  (chain[i]),
      .chain_out (chain[i+1]),
      .word_q    (words[i])
    );
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    round_nxt     = round_r;
    priority if (in_fire) begin
      out_valid_nxt = 1'b1;
      round_nxt     = '0;
    end else if (out_fire) begin
      if (is_last) begin
        out_valid_nxt = 1'b0;
      end else begin
        round_nxt = round_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      round_r     <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      round_r     <= round_nxt;
    end
  end

  assign in_stall           = out_valid_r;
  assign out_valid          = out_valid_r;
  assign out_round_number   = round_r;
  assign out_round_key_high = {words[0], words[1]};
  assign out_round_key_low  = {words[2], words[3]};
  assign out_last_key       = is_last;

  `AESKX_ASSERT_NEXT(a_start_round0, clk, rst_n, in_fire,
                     out_valid_r && (round_r == '0),
                     "accepted key did not start at round key 0")

  `AESKX_ASSERT_NEXT(a_round_advance, clk, rst_n, out_fire && !is_last,
                     out_valid_r && (round_r == $past(round_r) + 1'b1)
                     && (words[NumWords-1] == $past(chain[NumWords])),
                     "round key did not advance after a transaction")

  `AESKX_ASSERT_NEXT(a_run_ends, clk, rst_n, out_fire && is_last, !out_valid_r,
                     "output still valid after the last round key")

endmodule

// ===== rtl/aeskx_word_cell.sv =====
// One 32-bit word of the round key, a link in the XOR chain across the key.
module aeskx_word_cell (
  input  logic                        clk,
  input  aeskx_pkg::cell_ctrl_t       ctrl,
  input  logic [aeskx_pkg::WordW-1:0] load_word,
  input  logic [aeskx_pkg::WordW-1:0] chain_in,
  output logic [aeskx_pkg::WordW-1:0] chain_out,
  output logic [aeskx_pkg::WordW-1:0] word_q
);

  logic [aeskx_pkg::WordW-1:0] word_r;
  logic [aeskx_pkg::WordW-1:0] word_nxt;

  // The next value of this word is also what the right-hand neighbor XORs in.
  assign chain_out = word_r ^ chain_in;
  assign word_q    = word_r;

  always_comb begin
    priority if (ctrl.load) begin
      word_nxt = load_word;
    end else if (ctrl.step) begin
      word_nxt = chain_out;
    end else begin
      word_nxt = word_r;
    end
  end

  always_ff @(posedge clk) begin
    word_r <= word_nxt;
  end

endmodule

// ===== rtl/aeskx_gfunc.sv =====
// Key schedule core function: byte rotation, S-box substitution and round constant.
module aeskx_gfunc (
  input  logic [aeskx_pkg::WordW-1:0] word_in,
  input  logic [7:0]                  rcon_byte,
  output logic [aeskx_pkg::WordW-1:0] word_out
);

  logic [aeskx_pkg::WordW-1:0] rot;

  assign rot = {word_in[23:0], word_in[31:24]};

  assign word_out = {aeskx_pkg::sub_byte(rot[31:24]) ^ rcon_byte,
                     aeskx_pkg::sub_byte(rot[23:16]),
                     aeskx_pkg::sub_byte(rot[15:8]),
                     aeskx_pkg::sub_byte(rot[7:0])};

endmodule

// ===== bench/aes128_key_expansion_core_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench of the AES-128 key expansion core with its own round-key predictor.
module aes128_key_expansion_core_tb;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned NumRandomKeys = 248;
  localparam int unsigned QuietTail = 40;

  typedef struct {
    logic [3:0]  round_number;
    logic [63:0] key_high;
    logic [63:0] key_low;
    logic        last_key;
  } round_key_t;

  typedef struct {
    logic [63:0] key_high;
    logic [63:0] key_low;
    bit          pinned;
    logic [63:0] final_high;
    logic [63:0] final_low;
  } key_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  logic [63:0] in_key_high;
  logic [63:0] in_key_low;
  logic        out_valid;
  logic        out_stall;
  logic [3:0]  out_round_number;
  logic [63:0] out_round_key_high;
  logic [63:0] out_round_key_low;
  logic        out_last_key;

  round_key_t  round_keys_due[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  bit          gaps_on;
  bit          stall_on;
  int unsigned stall_burst;

  // Keys with a well-known final round key carry it in the table.
  key_row_t key_rows [12] = '{
    '{64'h0000000000000000, 64'h0000000000000000, 1'b1,
      64'hb4ef5bcb3e92e211, 64'h23e951cf6f8f188e},
    '{64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, 1'b1,
      64'hd014f9a8c9ee2589, 64'he13f0cc8b6630ca6},
    '{64'h0001020304050607, 64'h08090a0b0c0d0e0f, 1'b1,
      64'h13111d7fe3944a17, 64'hf307a78b4d2b30c5},
    '{64'hffffffffffffffff, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{64'hffffffffffffffff, 64'h0000000000000000, 1'b0, 64'h0, 64'h0},
    '{64'h0000000000000000, 64'hffffffffffffffff, 1'b0, 64'h0, 64'h0},
    '{64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 1'b0, 64'h0, 64'h0},
    '{64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 1'b0, 64'h0, 64'h0},
    '{64'h8000000000000000, 64'h0000000000000001, 1'b0, 64'h0, 64'h0},
    '{64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0, 64'h0, 64'h0},
    '{64'hffffffff00000000, 64'h00000000ffffffff, 1'b0, 64'h0, 64'h0},
    '{64'h0000000000000000, 64'h00000000000000ff, 1'b0, 64'h0, 64'h0}
  };

  aes128_key_expansion_core u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_key_high       (in_key_high),
    .in_key_low        (in_key_low),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_round_number  (out_round_number),
    .out_round_key_high(out_round_key_high),
    .out_round_key_low (out_round_key_low),
    .out_last_key      (out_last_key)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    logic [7:0] x;
    p = 8'h00;
    x = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= x;
      x = {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  // S-box from its definition: inverse in GF(2^8) as b^254, then the affine map.
  function automatic logic [7:0] sbox_of(input logic [7:0] b);
    logic [7:0] inv;
    logic [7:0] sq;
    inv = 8'h01;
    sq = b;
    for (int e = 0; e < 8; e++) begin
      if (e != 0) inv = gf_mul(inv, sq);
      sq = gf_mul(sq, sq);
    end
    return inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
         ^ {inv[3:0], inv[7:4]} ^ 8'h63;
  endfunction

  task automatic predict_round_keys(input logic [63:0] key_high, input logic [63:0] key_low);
    logic [31:0] w [4];
    logic [31:0] t;
    logic [7:0]  rc;
    round_key_t  rk;
    w[0] = key_high[63:32];
    w[1] = key_high[31:0];
    w[2] = key_low[63:32];
    w[3] = key_low[31:0];
    rc = 8'h01;
    for (int r = 0; r <= 10; r++) begin
      if (r != 0) begin
        t = {w[3][23:0], w[3][31:24]};
        t = {sbox_of(t[31:24]), sbox_of(t[23:16]), sbox_of(t[15:8]), sbox_of(t[7:0])}
          ^ {rc, 24'h000000};
        w[0] ^= t;
        w[1] ^= w[0];
        w[2] ^= w[1];
        w[3] ^= w[2];
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end
      rk.round_number = r[3:0];
      rk.key_high = {w[0], w[1]};
      rk.key_low = {w[2], w[3]};
      rk.last_key = (r == 10);
      round_keys_due.push_back(rk);
    end
  endtask

  // Drives one key and waits for its transaction; expectations are queued at acceptance.
  task automatic send_key(input key_row_t row);
    int unsigned gap;
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 5);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_key_high <= row.key_high;
    in_key_low <= row.key_low;
    do @(posedge clk); while (in_stall);
    predict_round_keys(row.key_high, row.key_low);
    if (row.pinned) begin
      round_keys_due[$].key_high = row.final_high;
      round_keys_due[$].key_low = row.final_low;
    end
  endtask

  task automatic drain_round_keys();
    in_valid <= 1'b0;
    while (round_keys_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n || !stall_on) begin
      out_stall <= 1'b0;
      stall_burst <= 0;
    end else if (stall_burst != 0) begin
      out_stall <= 1'b1;
      stall_burst <= stall_burst - 1;
    end else if (!out_stall && $urandom_range(0, 4) == 0) begin
      out_stall <= 1'b1;
      stall_burst <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    round_key_t rk;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (round_keys_due.size() == 0) begin
          $error("round key %0d arrived with nothing expected", out_round_number);
          mismatch_count++;
        end else begin
          rk = round_keys_due.pop_front();
          if (out_round_number !== rk.round_number) begin
            $error("round_number: expected %0d, got %0d", rk.round_number, out_round_number);
            mismatch_count++;
          end
          if (out_round_key_high !== rk.key_high) begin
            $error("round_key_high: expected %h, got %h", rk.key_high, out_round_key_high);
            mismatch_count++;
          end
          if (out_round_key_low !== rk.key_low) begin
            $error("round_key_low: expected %h, got %h", rk.key_low, out_round_key_low);
            mismatch_count++;
          end
          if (out_last_key !== rk.last_key) begin
            $error("last_key: expected %0b, got %0b", rk.last_key, out_last_key);
            mismatch_count++;
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= StallLimit) begin
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  initial begin
    key_row_t row;
    int unsigned mode;
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_key_high <= 64'h0;
    in_key_low <= 64'h0;
    gaps_on = 1'b0;
    stall_on <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (key_rows[i]) send_key(key_rows[i]);
    drain_round_keys();

    row.pinned = 1'b0;
    row.final_high = 64'h0;
    row.final_low = 64'h0;
    for (int i = 0; i < NumRandomKeys; i++) begin
      // The sender reads gaps_on at once, so it takes effect in this same iteration.
      if (i < NumRandomKeys - QuietTail) begin
        gaps_on = ((i / 30) % 3) != 2;
        stall_on <= ((i / 30) % 3) != 1;
      end else begin
        gaps_on = 1'b0;
        stall_on <= 1'b0;
      end
      // The sender holds off once mid-run until every round key is out.
      if (i == NumRandomKeys / 2) drain_round_keys();
      mode = $urandom_range(0, 3);
      row.key_high = {$urandom, $urandom};
      row.key_low = {$urandom, $urandom};
      if (mode == 0) begin
        row.key_high &= {$urandom, $urandom} & {$urandom, $urandom};
        row.key_low &= {$urandom, $urandom} & {$urandom, $urandom};
      end else if (mode == 1) begin
        row.key_high |= {$urandom, $urandom} | {$urandom, $urandom};
        row.key_low |= {$urandom, $urandom} | {$urandom, $urandom};
      end
      send_key(row);
    end

    drain_round_keys();
    repeat (24) @(posedge clk);
    if (mismatch_count == 0 && round_keys_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/aeskx_pkg.sv
rtl/aeskx_word_cell.sv
rtl/aeskx_gfunc.sv
rtl/aes128_key_expansion_core.sv
bench/aes128_key_expansion_core_tb.sv
